[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files of the sector cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked implication, disabled while the synchronous reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/scrr_pkg.sv]
// Types and constants shared by the sector cache tag engine.
`timescale 1ns / 1ps
`default_nettype none

package scrr_pkg;

    localparam int TOTAL_W    = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = 32;
    localparam int SLOT_W     = 3;
    localparam int NUM_CNT    = 7;

    localparam int CNT_RDREQ  = 0;
    localparam int CNT_WRREQ  = 1;
    localparam int CNT_HITS   = 2;
    localparam int CNT_MISSES = 3;
    localparam int CNT_ERRORS = 4;
    localparam int CNT_DEVRD  = 5;
    localparam int CNT_DEVWR  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACHED    = 1'b0,
        REG_BLOCK_TOTAL = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NODEV  = 2'd1,
        ST_RANGE  = 2'd2,
        ST_DEVERR = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    // Update command from the controller to one tag cell.
    typedef struct packed {
        logic clear;
        logic load;
        logic inval;
    } t_cell_cmd;

endpackage

`default_nettype wire

[hw/rtl/scrr_cell.sv]
// One tag cell of the search chain: holds one entry and passes the probe on.
`timescale 1ns / 1ps
`default_nettype none

module scrr_cell
    import scrr_pkg::*;
#(
    parameter int TAG_W    = 48,
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [TAG_W-1:0] i_load_tag,
    input  wire logic [TAG_W-1:0] i_probe_tag,
    input  wire logic             i_probe_hit,
    input  wire logic [IDX_W-1:0] i_probe_idx,
    output logic      [TAG_W-1:0] o_probe_tag,
    output logic                  o_probe_hit,
    output logic      [IDX_W-1:0] o_probe_idx
);

    logic             r_valid;
    logic [TAG_W-1:0] r_tag;
    logic [TAG_W-1:0] r_probe_tag;
    logic             r_probe_hit;
    logic [IDX_W-1:0] r_probe_idx;
    logic             w_match;

    // An earlier cell that already matched keeps its index: first match wins.
    assign w_match = r_valid && (r_tag == i_probe_tag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_probe_hit <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end else if (i_cmd.load) begin
                r_valid <= 1'b1;
            end else if (i_cmd.inval) begin
                r_valid <= 1'b0;
            end
            r_probe_hit <= i_probe_hit | w_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !i_cmd.clear) begin
            r_tag <= i_load_tag;
        end
        r_probe_tag <= i_probe_tag;
        r_probe_idx <= i_probe_hit ? i_probe_idx : IDX_W'(CELL_IDX);
    end

    assign o_probe_tag = r_probe_tag;
    assign o_probe_hit = r_probe_hit;
    assign o_probe_idx = r_probe_idx;

endmodule

`default_nettype wire

[hw/rtl/sector_cache_round_robin.sv]
// Top level of the sector cache tag engine: request control, counters and the cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Tag and policy engine of a fully associative, write-through sector cache with
// round-robin replacement and no allocation on write.
// A request item (type, block number, device outcome) is taken at a rising edge
// where start is high and busy is low. The block number is latched and walks
// down a chain of ENTRIES tag cells, one cell per cycle; each cell compares it
// with its own entry, and the first valid match is carried to the end.
// At the end of the walk the policy is applied: the victim cell is filled or
// invalidated, the counters count, and the result item appears on the output
// ports for exactly one cycle with o_done high.
// The result is registered in the finishing state and shown after it. Busy
// stays high until the result is shown, so no new item is taken while one is
// still walking down the cell chain or being decided.
// A new item may be started in the very cycle in which o_done is high.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// The configuration port writes a register at every edge with i_cfg_we high.
// Writing the attach register clears all valid bits, counters and the victim
// pointer in that same cycle. Reset leaves the device detached, every entry
// invalid and all counters at zero; no clearing pass is needed.

`include "assert_macros.svh"

module sector_cache_round_robin
    import scrr_pkg::*;
#(
    parameter int ENTRIES         = 8,
    parameter int BLOCK_ADDR_BITS = 48
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_req_type,
    input  wire logic [BLOCK_ADDR_BITS-1:0] i_block_number,
    input  wire logic                       i_device_ok,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic                            o_hit,
    output logic [SLOT_W-1:0]               o_slot,
    output logic                            o_fill,
    output logic [CNT_W-1:0]                o_read_requests_total,
    output logic [CNT_W-1:0]                o_write_requests_total,
    output logic [CNT_W-1:0]                o_hits_total,
    output logic [CNT_W-1:0]                o_misses_total,
    output logic [CNT_W-1:0]                o_errors_total,
    output logic [CNT_W-1:0]                o_device_reads_total,
    output logic [CNT_W-1:0]                o_device_writes_total
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W = (BLOCK_ADDR_BITS > TOTAL_W) ? BLOCK_ADDR_BITS : TOTAL_W;

    // Control state.
    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_step;
    logic [IDX_W-1:0]         r_victim;
    logic                     r_attached;
    logic [TOTAL_W-1:0]       r_block_total;
    logic [CNT_W-1:0]         r_counters [NUM_CNT];
    logic                     r_done;

    // Latched request.
    logic                       r_is_write;
    logic [BLOCK_ADDR_BITS-1:0] r_block;
    logic                       r_dev_ok;

    // Result registers.
    logic [1:0]        r_status;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic              r_fill;

    // Decision outputs.
    t_status           n_status;
    logic              n_hit;
    logic [IDX_W-1:0]  n_slot_idx;
    logic              n_fill;
    logic [NUM_CNT-1:0] w_inc;
    logic              w_advance;
    logic              w_do_load;
    logic              w_do_inval;
    logic              w_in_range;
    logic              w_accept;
    logic              w_clear;

    // Probe chain between the cells.
    logic [BLOCK_ADDR_BITS-1:0] w_tag [ENTRIES+1];
    logic                       w_hit [ENTRIES+1];
    logic [IDX_W-1:0]           w_idx [ENTRIES+1];

    assign w_accept = start && !busy;
    assign w_clear  = i_cfg_we && (i_cfg_index == REG_ATTACHED);
    assign busy     = (r_state != S_IDLE);

    assign w_tag[0] = r_block;
    assign w_hit[0] = 1'b0;
    assign w_idx[0] = '0;

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            t_cell_cmd w_cmd;

            assign w_cmd.clear = w_clear;
            assign w_cmd.load  = w_do_load && (r_victim == IDX_W'(k));
            assign w_cmd.inval = w_do_inval && (r_victim == IDX_W'(k));

            scrr_cell #(
                .TAG_W    (BLOCK_ADDR_BITS),
                .IDX_W    (IDX_W),
                .CELL_IDX (k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_load_tag  (r_block),
                .i_probe_tag (w_tag[k]),
                .i_probe_hit (w_hit[k]),
                .i_probe_idx (w_idx[k]),
                .o_probe_tag (w_tag[k+1]),
                .o_probe_hit (w_hit[k+1]),
                .o_probe_idx (w_idx[k+1])
            );
        end
    endgenerate

    // Next state: the search runs until the probe has left the last cell, and the
    // policy is applied in the cycle after.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_step == IDX_W'(ENTRIES - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_in_range = CMP_W'(r_block) < CMP_W'(r_block_total);

    // Policy decision, taken on the chain result while in the finishing state.
    always_comb begin
        n_status   = ST_OK;
        n_hit      = 1'b0;
        n_slot_idx = '0;
        n_fill     = 1'b0;
        w_inc      = '0;
        w_advance  = 1'b0;
        w_do_load  = 1'b0;
        w_do_inval = 1'b0;
        if (r_state == S_FINISH) begin
            if (!r_attached) begin
                n_status = ST_NODEV;
            end else if (!r_is_write) begin
                w_inc[CNT_RDREQ] = 1'b1;
                if (!w_in_range) begin
                    w_inc[CNT_ERRORS] = 1'b1;
                    n_status          = ST_RANGE;
                end else if (w_hit[ENTRIES]) begin
                    w_inc[CNT_HITS] = 1'b1;
                    n_hit           = 1'b1;
                    n_slot_idx      = w_idx[ENTRIES];
                end else begin
                    // Read miss: the victim is taken in turn, whatever the
                    // device outcome.
                    w_advance         = 1'b1;
                    w_inc[CNT_MISSES] = 1'b1;
                    n_slot_idx        = r_victim;
                    if (r_dev_ok) begin
                        w_inc[CNT_DEVRD] = 1'b1;
                        w_do_load        = 1'b1;
                        n_fill           = 1'b1;
                    end else begin
                        w_inc[CNT_ERRORS] = 1'b1;
                        w_do_inval        = 1'b1;
                        n_status          = ST_DEVERR;
                    end
                end
            end else begin
                w_inc[CNT_WRREQ] = 1'b1;
                if (!w_in_range) begin
                    w_inc[CNT_ERRORS] = 1'b1;
                    n_status          = ST_RANGE;
                end else if (!r_dev_ok) begin
                    w_inc[CNT_ERRORS] = 1'b1;
                    n_status          = ST_DEVERR;
                end else begin
                    // Write-through: a matching entry keeps its tag, nothing
                    // is allocated.
                    w_inc[CNT_DEVWR] = 1'b1;
                    if (w_hit[ENTRIES]) begin
                        n_hit      = 1'b1;
                        n_slot_idx = w_idx[ENTRIES];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= '0;
            r_victim      <= '0;
            r_attached    <= 1'b0;
            r_block_total <= '0;
            r_done        <= 1'b0;
            for (int c = 0; c < NUM_CNT; c++) begin
                r_counters[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FINISH);
            if (r_state == S_SEARCH) begin
                r_step <= r_step + IDX_W'(1);
            end else begin
                r_step <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ATTACHED: begin
                        r_attached <= i_cfg_data[0];
                    end
                    REG_BLOCK_TOTAL: begin
                        r_block_total <= i_cfg_data[TOTAL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_clear) begin
                r_victim <= '0;
                for (int c = 0; c < NUM_CNT; c++) begin
                    r_counters[c] <= '0;
                end
            end else begin
                if (w_advance) begin
                    r_victim <= (r_victim == IDX_W'(ENTRIES - 1)) ? '0
                                                                   : r_victim + IDX_W'(1);
                end
                for (int c = 0; c < NUM_CNT; c++) begin
                    r_counters[c] <= r_counters[c] + CNT_W'(w_inc[c]);
                end
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_write <= i_req_type;
            r_block    <= i_block_number;
            r_dev_ok   <= i_device_ok;
        end
        if (r_state == S_FINISH) begin
            r_status <= n_status;
            r_hit    <= n_hit;
            r_slot   <= SLOT_W'(n_slot_idx);
            r_fill   <= n_fill;
        end
    end

    assign o_done                 = r_done;
    assign o_status               = r_status;
    assign o_hit                  = r_hit;
    assign o_slot                 = r_slot;
    assign o_fill                 = r_fill;
    assign o_read_requests_total  = r_counters[CNT_RDREQ];
    assign o_write_requests_total = r_counters[CNT_WRREQ];
    assign o_hits_total           = r_counters[CNT_HITS];
    assign o_misses_total         = r_counters[CNT_MISSES];
    assign o_errors_total         = r_counters[CNT_ERRORS];
    assign o_device_reads_total   = r_counters[CNT_DEVRD];
    assign o_device_writes_total  = r_counters[CNT_DEVWR];

    `ASSERT_CLK(a_done_single, o_done |=> !o_done, "result strobe held for more than one cycle")
    `ASSERT_IMPL(a_probe_arrived, r_state == S_FINISH, w_tag[ENTRIES] == r_block, "probe tag not at chain end when deciding")
    `ASSERT_IMPL(a_fill_clean, o_done && o_fill, (o_status == ST_OK) && !o_hit, "fill reported with hit or error")
    `ASSERT_IMPL(a_victim_range, 1'b1, r_victim <= IDX_W'(ENTRIES - 1), "victim pointer out of range")

endmodule

`default_nettype wire
